// ===== design/mmsb_pkg.sv =====
package mmsb_pkg;
   localparam int MAX_DIM_DEF = 8;
   localparam int VAL_W = 32;
   localparam int IDX_W = 3;
   localparam int DIM_W = 4;

   typedef enum logic [1:0] {
      CMD_WR_A = 2'd0,
      CMD_WR_B = 2'd1,
      CMD_COMPUTE = 2'd2,
      CMD_NONE = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      CSR_A_ROWS = 2'd0,
      CSR_A_COLS = 2'd1,
      CSR_B_ROWS = 2'd2,
      CSR_B_COLS = 2'd3
   } csr_type;

   typedef enum logic [1:0] {
      MODE_PROD = 2'd0,
      MODE_SCALE_A = 2'd1,
      MODE_SCALE_B = 2'd2,
      MODE_ERR = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MAC,
      ST_WAIT,
      ST_SUM,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic [IDX_W-1:0] rows_m1;
      logic [IDX_W-1:0] cols_m1;
      logic [IDX_W-1:0] inner_m1;
      mode_type mode;
   } job_type;
endpackage

// ===== design/mmsb_front.sv =====
module mmsb_front
   import mmsb_pkg::*;
#(
   parameter int MAX_DIM = MAX_DIM_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic csr_write,
   input  logic [1:0] csr_index,
   input  logic [DIM_W-1:0] csr_data,
   input  logic req_valid,
   output logic req_stall,
   input  logic [1:0] req_command,
   input  logic [IDX_W-1:0] req_row_index,
   input  logic [IDX_W-1:0] req_col_index,
   input  logic signed [VAL_W-1:0] req_elem_value,
   output logic wr_a,
   output logic wr_b,
   output logic [2*$clog2(MAX_DIM)-1:0] wr_addr,
   output logic [VAL_W-1:0] wr_data,
   output logic job_valid,
   input  logic job_stall,
   output job_type job
);
   localparam int DW = $clog2(MAX_DIM);
   localparam int AW = 2*DW;
   logic [DIM_W-1:0] a_rows_ff, a_cols_ff, b_rows_ff, b_cols_ff;
   logic [DIM_W-1:0] ar, ac, br, bc;
   logic q_valid_ff;
   job_type q_job_ff, job_in;
   logic acc_req;

   function automatic logic [DIM_W-1:0] eff(input logic [DIM_W-1:0] r);
      if (r == '0) return DIM_W'(1);
      if (r > DIM_W'(MAX_DIM)) return DIM_W'(MAX_DIM);
      return r;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         a_rows_ff <= DIM_W'(1);
         a_cols_ff <= DIM_W'(1);
         b_rows_ff <= DIM_W'(1);
         b_cols_ff <= DIM_W'(1);
      end else if (csr_write) begin
         unique case (csr_type'(csr_index))
            CSR_A_ROWS: a_rows_ff <= csr_data;
            CSR_A_COLS: a_cols_ff <= csr_data;
            CSR_B_ROWS: b_rows_ff <= csr_data;
            CSR_B_COLS: b_cols_ff <= csr_data;
         endcase
      end
   end

   assign ar = eff(a_rows_ff);
   assign ac = eff(a_cols_ff);
   assign br = eff(b_rows_ff);
   assign bc = eff(b_cols_ff);

   assign req_stall = q_valid_ff;
   assign acc_req = req_valid && !req_stall;

   always_comb begin
      job_in = '0;
      if (ac == br) begin
         job_in.mode = MODE_PROD;
         job_in.rows_m1 = IDX_W'(ar - 1'b1);
         job_in.cols_m1 = IDX_W'(bc - 1'b1);
         job_in.inner_m1 = IDX_W'(ac - 1'b1);
      end else if (ar == DIM_W'(1) && ac == DIM_W'(1)) begin
         job_in.mode = MODE_SCALE_A;
         job_in.rows_m1 = IDX_W'(br - 1'b1);
         job_in.cols_m1 = IDX_W'(bc - 1'b1);
      end else if (br == DIM_W'(1) && bc == DIM_W'(1)) begin
         job_in.mode = MODE_SCALE_B;
         job_in.rows_m1 = IDX_W'(ar - 1'b1);
         job_in.cols_m1 = IDX_W'(ac - 1'b1);
      end else begin
         job_in.mode = MODE_ERR;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_valid_ff <= 1'b0;
      end else if (acc_req && cmd_type'(req_command) == CMD_COMPUTE) begin
         q_valid_ff <= 1'b1;
      end else if (q_valid_ff && !job_stall) begin
         q_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (acc_req && cmd_type'(req_command) == CMD_COMPUTE) begin
         q_job_ff <= job_in;
      end
   end

   assign wr_a = acc_req && cmd_type'(req_command) == CMD_WR_A
      && {1'b0, req_row_index} < ar && {1'b0, req_col_index} < ac;
   assign wr_b = acc_req && cmd_type'(req_command) == CMD_WR_B
      && {1'b0, req_row_index} < br && {1'b0, req_col_index} < bc;
   assign wr_addr = AW'({req_row_index[DW-1:0], req_col_index[DW-1:0]});
   assign wr_data = req_elem_value;
   assign job_valid = q_valid_ff;
   assign job = q_job_ff;
endmodule

// ===== design/mmsb_back.sv =====
module mmsb_back
   import mmsb_pkg::*;
#(
   parameter int MAX_DIM = MAX_DIM_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic wr_a,
   input  logic wr_b,
   input  logic [2*$clog2(MAX_DIM)-1:0] wr_addr,
   input  logic [VAL_W-1:0] wr_data,
   input  logic job_valid,
   output logic job_stall,
   input  job_type job,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic [IDX_W-1:0] rsp_out_row,
   output logic [IDX_W-1:0] rsp_out_col,
   output logic signed [VAL_W-1:0] rsp_out_value,
   output logic rsp_last_element,
   output logic rsp_dim_error,
   output logic busy
);
   localparam int DW = $clog2(MAX_DIM);
   localparam int AW = 2*DW;
   localparam int CELLS = 1 << AW;
   localparam int ACC_W = 64 + 4;

   logic [VAL_W-1:0] mem_a [CELLS];
   logic [VAL_W-1:0] mem_b [CELLS];
   logic [CELLS-1:0] va_ff, vb_ff;
   logic [VAL_W-1:0] rd_a_ff, rd_b_ff;
   logic rva_ff, rvb_ff;
   logic [AW-1:0] ra_addr, rb_addr;

   state_type st_ff, st_in;
   job_type job_ff;
   logic [IDX_W-1:0] i_ff, j_ff, k_ff;
   logic rd_ff, prod_v_ff;
   logic signed [63:0] prod_ff;
   logic signed [ACC_W-1:0] acc_ff;
   logic out_v_ff;
   logic [IDX_W-1:0] o_row_ff, o_col_ff;
   logic [VAL_W-1:0] o_val_ff;
   logic o_last_ff, o_err_ff;
   logic signed [VAL_W-1:0] opa, opb;
   logic signed [ACC_W-1:0] shifted;
   logic [VAL_W-1:0] sat;
   logic k_done, out_free;

   always_ff @(posedge clock) begin
      if (wr_a) mem_a[wr_addr] <= wr_data;
      if (wr_b) mem_b[wr_addr] <= wr_data;
      rd_a_ff <= mem_a[ra_addr];
      rd_b_ff <= mem_b[rb_addr];
      rva_ff <= va_ff[ra_addr];
      rvb_ff <= vb_ff[rb_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= '0;
         vb_ff <= '0;
      end else begin
         if (wr_a) va_ff[wr_addr] <= 1'b1;
         if (wr_b) vb_ff[wr_addr] <= 1'b1;
      end
   end

   always_comb begin
      unique case (job_ff.mode)
         MODE_PROD: begin
            ra_addr = AW'({i_ff[DW-1:0], k_ff[DW-1:0]});
            rb_addr = AW'({k_ff[DW-1:0], j_ff[DW-1:0]});
         end
         MODE_SCALE_A: begin
            ra_addr = '0;
            rb_addr = AW'({i_ff[DW-1:0], j_ff[DW-1:0]});
         end
         MODE_SCALE_B: begin
            ra_addr = AW'({i_ff[DW-1:0], j_ff[DW-1:0]});
            rb_addr = '0;
         end
         default: begin
            ra_addr = '0;
            rb_addr = '0;
         end
      endcase
   end

   assign opa = rva_ff ? signed'(rd_a_ff) : '0;
   assign opb = rvb_ff ? signed'(rd_b_ff) : '0;
   assign k_done = (job_ff.mode != MODE_PROD) || (k_ff == job_ff.inner_m1);
   assign out_free = !out_v_ff || !rsp_stall;
   assign shifted = acc_ff >>> 16;

   always_comb begin
      if (shifted > ACC_W'(64'sd2147483647)) sat = 32'h7fffffff;
      else if (shifted < -ACC_W'(64'sd2147483648)) sat = 32'h80000000;
      else sat = shifted[VAL_W-1:0];
   end

   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         ST_IDLE: if (job_valid) st_in = (job.mode == MODE_ERR) ? ST_OUT : ST_MAC;
         ST_MAC: if (k_done) st_in = ST_WAIT;
         ST_WAIT: if (!rd_ff && !prod_v_ff) st_in = ST_SUM;
         ST_SUM: st_in = ST_OUT;
         ST_OUT: begin
            if (out_free) begin
               if (job_ff.mode == MODE_ERR ||
                   (i_ff == job_ff.rows_m1 && j_ff == job_ff.cols_m1)) st_in = ST_IDLE;
               else st_in = ST_MAC;
            end
         end
         default: st_in = ST_IDLE;
      endcase
   end

   assign job_stall = st_ff != ST_IDLE;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE;
         rd_ff <= 1'b0;
         prod_v_ff <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         rd_ff <= st_ff == ST_MAC;
         prod_v_ff <= rd_ff;
         if (st_ff == ST_OUT && out_free) out_v_ff <= 1'b1;
         else if (!rsp_stall) out_v_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (prod_v_ff) acc_ff <= acc_ff + ACC_W'(prod_ff);
      if (rd_ff) prod_ff <= opa * opb;
      unique case (st_ff)
         ST_IDLE: begin
            job_ff <= job;
            i_ff <= '0;
            j_ff <= '0;
            k_ff <= '0;
            acc_ff <= '0;
         end
         ST_MAC: if (!k_done) k_ff <= k_ff + 1'b1;
         ST_OUT: begin
            if (out_free) begin
               o_row_ff <= (job_ff.mode == MODE_ERR) ? '0 : i_ff;
               o_col_ff <= (job_ff.mode == MODE_ERR) ? '0 : j_ff;
               o_val_ff <= (job_ff.mode == MODE_ERR) ? '0 : sat;
               o_err_ff <= job_ff.mode == MODE_ERR;
               o_last_ff <= job_ff.mode == MODE_ERR ||
                  (i_ff == job_ff.rows_m1 && j_ff == job_ff.cols_m1);
               k_ff <= '0;
               acc_ff <= '0;
               if (j_ff == job_ff.cols_m1) begin
                  j_ff <= '0;
                  i_ff <= i_ff + 1'b1;
               end else begin
                  j_ff <= j_ff + 1'b1;
               end
            end
         end
         default: ;
      endcase
   end

   assign rsp_valid = out_v_ff;
   assign rsp_out_row = o_row_ff;
   assign rsp_out_col = o_col_ff;
   assign rsp_out_value = o_val_ff;
   assign rsp_last_element = o_last_ff;
   assign rsp_dim_error = o_err_ff;
   assign busy = st_ff != ST_IDLE;
endmodule

// ===== design/matrix_multiply_scalar_broadcast.sv =====
// Loads and config writes: one transfer per cycle (loads only while req_stall is
// low), no result. Compute: results leave one at a time, each from one shared
// 32x32 multiplier: read, multiply, accumulate, saturate (inner_dim is 1 when
// scaling); an error job gives a single error result.
// Input stalls from the compute transfer until its last result is registered.
// Reset is synchronous, active high: dimensions go to 1, stores read as zero.
module matrix_multiply_scalar_broadcast
   import mmsb_pkg::*;
#(
   parameter int MAX_DIM = MAX_DIM_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic csr_write,
   input  logic [1:0] csr_index,
   input  logic [DIM_W-1:0] csr_data,
   input  logic req_valid,
   output logic req_stall,
   input  logic [1:0] req_command,
   input  logic [IDX_W-1:0] req_row_index,
   input  logic [IDX_W-1:0] req_col_index,
   input  logic signed [VAL_W-1:0] req_elem_value,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic [IDX_W-1:0] rsp_out_row,
   output logic [IDX_W-1:0] rsp_out_col,
   output logic signed [VAL_W-1:0] rsp_out_value,
   output logic rsp_last_element,
   output logic rsp_dim_error
);
   logic wr_a, wr_b, job_valid, job_stall, busy, f_stall;
   logic [2*$clog2(MAX_DIM)-1:0] wr_addr;
   logic [VAL_W-1:0] wr_data;
   job_type job;
   logic req_valid_gated;

   // loads must not overtake a pending compute
   assign req_valid_gated = req_valid && !busy;
   assign req_stall = f_stall || busy;

   mmsb_front #(.MAX_DIM(MAX_DIM)) u_front (
      .clock(clock), .reset(reset),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data),
      .req_valid(req_valid_gated), .req_stall(f_stall),
      .req_command(req_command), .req_row_index(req_row_index),
      .req_col_index(req_col_index), .req_elem_value(req_elem_value),
      .wr_a(wr_a), .wr_b(wr_b), .wr_addr(wr_addr), .wr_data(wr_data),
      .job_valid(job_valid), .job_stall(job_stall), .job(job)
   );

   mmsb_back #(.MAX_DIM(MAX_DIM)) u_back (
      .clock(clock), .reset(reset),
      .wr_a(wr_a), .wr_b(wr_b), .wr_addr(wr_addr), .wr_data(wr_data),
      .job_valid(job_valid), .job_stall(job_stall), .job(job),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_out_row(rsp_out_row), .rsp_out_col(rsp_out_col),
      .rsp_out_value(rsp_out_value), .rsp_last_element(rsp_last_element),
      .rsp_dim_error(rsp_dim_error), .busy(busy)
   );

`ifndef SYNTHESIS
   a_err_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_dim_error |-> rsp_last_element && rsp_out_value == '0)
      else $error("error result malformed");
   a_no_write_busy: assert property (@(posedge clock) disable iff (reset)
      busy |-> !wr_a && !wr_b)
      else $error("store write during compute");
   a_job_held: assert property (@(posedge clock) disable iff (reset)
      job_valid && job_stall |=> job_valid)
      else $error("queued job lost");
`endif
endmodule
